@@ hdl/vca_pkg.sv @@
`timescale 1ns / 1ps

package vca_pkg;

    // Field widths of the request and result transfers
    localparam int FUNC_W      = 2;
    localparam int ID_W        = 8;
    localparam int TIME_W      = 31;
    localparam int CHAN_OUT_W  = 6;
    localparam int COUNT_OUT_W = 7;

    // Default table size
    localparam int CHANNELS_DEFAULT = 64;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_ASSIGN_MUSIC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ASSIGN_WAVE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE_MUSIC = 2'd2;

    // Owner id of a channel that no music holds
    localparam logic [ID_W-1:0] NO_MUSIC = 8'hFF;

    // Channel usage
    typedef enum logic [1:0] {
        KIND_UNUSED = 2'd0,
        KIND_MUSIC  = 2'd1,
        KIND_WAVE   = 2'd2
    } kind_t;

    // Status of the scan unit towards the sequencer
    typedef struct packed {
        logic have_unused;
        logic have_wave;
        logic match;
    } scan_flags_t;

endpackage

@@ hdl/vca_table.sv @@
`timescale 1ns / 1ps

module vca_table #(
    parameter int CHANNELS = vca_pkg::CHANNELS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // read port, registered: data in the cycle after rd_en
    input  logic                            rd_en,
    input  logic [$clog2(CHANNELS)-1:0]     rd_addr,
    output vca_pkg::kind_t                  rd_kind,
    output logic [vca_pkg::ID_W-1:0]        rd_owner,
    output logic [vca_pkg::TIME_W-1:0]      rd_start,
    // write port
    input  logic                            we,
    input  logic [$clog2(CHANNELS)-1:0]     waddr,
    input  vca_pkg::kind_t                  wkind,
    input  logic [vca_pkg::ID_W-1:0]        wowner,
    input  logic                            start_we,
    input  logic [vca_pkg::TIME_W-1:0]      wstart
);

    vca_pkg::kind_t                 kind_mem  [CHANNELS];
    logic [vca_pkg::ID_W-1:0]       owner_mem [CHANNELS];
    logic [vca_pkg::TIME_W-1:0]     start_mem [CHANNELS];

    logic [CHANNELS-1:0]            valid_reg;

    vca_pkg::kind_t                 kind_rd_reg;
    logic [vca_pkg::ID_W-1:0]       owner_rd_reg;
    logic [vca_pkg::TIME_W-1:0]     start_rd_reg;
    logic                           valid_rd_reg;

    // per-channel written flags, cleared at reset so the table reads empty at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[waddr] <= 1'b1;
            if (rd_en)
                valid_rd_reg <= valid_reg[rd_addr];
        end
    end

    // storage arrays, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            kind_mem[waddr]  <= wkind;
            owner_mem[waddr] <= wowner;
        end
        if (start_we)
            start_mem[waddr] <= wstart;
        if (rd_en)
        begin
            kind_rd_reg  <= kind_mem[rd_addr];
            owner_rd_reg <= owner_mem[rd_addr];
            start_rd_reg <= start_mem[rd_addr];
        end
    end

    // never-written entries read as unused with no owner
    assign rd_kind  = valid_rd_reg ? kind_rd_reg : vca_pkg::KIND_UNUSED;
    assign rd_owner = valid_rd_reg ? owner_rd_reg : vca_pkg::NO_MUSIC;
    assign rd_start = start_rd_reg;

endmodule

@@ hdl/vca_scan_unit.sv @@
`timescale 1ns / 1ps

module vca_scan_unit #(
    parameter int CHANNELS = vca_pkg::CHANNELS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clear,
    input  logic                            en,
    input  logic [$clog2(CHANNELS)-1:0]     idx,
    input  vca_pkg::kind_t                  kind,
    input  logic [vca_pkg::ID_W-1:0]        owner,
    input  logic [vca_pkg::TIME_W-1:0]      start,
    input  logic [vca_pkg::ID_W-1:0]        id,
    output vca_pkg::scan_flags_t            flags,
    output logic [$clog2(CHANNELS)-1:0]     unused_idx,
    output logic [$clog2(CHANNELS)-1:0]     wave_idx
);

    localparam int CH_W = $clog2(CHANNELS);

    logic               have_unused_reg;
    logic               have_wave_reg;
    logic [CH_W-1:0]    unused_idx_reg;
    logic [CH_W-1:0]    wave_idx_reg;
    logic [vca_pkg::TIME_W-1:0] oldest_reg;

    logic               is_unused;
    logic               take_wave;

    // the shared compare: oldest wave so far, strict so the lowest index wins ties
    always_comb
    begin
        is_unused = 1'b0;
        take_wave = 1'b0;
        case (kind)
            vca_pkg::KIND_UNUSED: is_unused = 1'b1;
            vca_pkg::KIND_WAVE:   take_wave = !have_wave_reg || (start < oldest_reg);
            default:              ;
        endcase
    end

    // running flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_unused_reg <= 1'b0;
            have_wave_reg   <= 1'b0;
        end
        else if (clear)
        begin
            have_unused_reg <= 1'b0;
            have_wave_reg   <= 1'b0;
        end
        else if (en)
        begin
            if (is_unused)
                have_unused_reg <= 1'b1;
            if (take_wave)
                have_wave_reg <= 1'b1;
        end
    end

    // candidates; ascending scan so the last unused seen is the highest
    always_ff @(posedge clk)
    begin
        if (en && !clear)
        begin
            if (is_unused)
                unused_idx_reg <= idx;
            if (take_wave)
            begin
                wave_idx_reg <= idx;
                oldest_reg   <= start;
            end
        end
    end

    assign flags.have_unused = have_unused_reg;
    assign flags.have_wave   = have_wave_reg;
    assign flags.match       = (kind == vca_pkg::KIND_MUSIC) && (owner == id);
    assign unused_idx        = unused_idx_reg;
    assign wave_idx          = wave_idx_reg;

endmodule

@@ hdl/voice_channel_allocator.sv @@
`timescale 1ns / 1ps

// Channel    Handshake                Payload
// request    in_valid / in_ready      func, music_id, now
// result     out_valid / out_ready    channel, no_channel, free_count
//
// One request at a time. Assign: the scan reads one table entry per cycle through the
// scan compare, then the grant state writes the chosen channel, if any, and the result.
// Release: the scan alone, freeing matching music channels as it passes; an undefined
// code goes straight to the result. After the result transfer the FSM returns to idle.
// Reset empties the table at once through per-channel written flags.
// in_ready stays low while a request is in work or its result is not taken.

module voice_channel_allocator #(
    parameter int CHANNELS = vca_pkg::CHANNELS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [vca_pkg::FUNC_W-1:0]          func,
    input  logic [vca_pkg::ID_W-1:0]            music_id,
    input  logic [vca_pkg::TIME_W-1:0]          now,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [vca_pkg::CHAN_OUT_W-1:0]      channel,
    output logic                                no_channel,
    output logic [vca_pkg::COUNT_OUT_W-1:0]     free_count
);

    localparam int CH_W  = $clog2(CHANNELS);
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CHANNELS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_GRANT,
        S_RESULT
    } state_t;

    state_t                         state_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               free_reg;
    logic [CH_W-1:0]                rd_idx_reg;
    logic [vca_pkg::FUNC_W-1:0]     func_reg;
    logic [vca_pkg::ID_W-1:0]       id_reg;
    logic [vca_pkg::TIME_W-1:0]     now_reg;
    logic                           out_valid_reg;
    logic [vca_pkg::CHAN_OUT_W-1:0] channel_reg;
    logic                           no_channel_reg;
    logic [vca_pkg::COUNT_OUT_W-1:0] free_count_reg;

    logic                           in_xfer;
    logic                           scan_en;
    logic                           rd_en;
    logic                           is_release;
    logic                           is_assign;
    logic                           grant_ok;
    logic [CH_W-1:0]                chosen;
    logic [CNT_W-1:0]               free_next;
    logic [vca_pkg::COUNT_OUT_W-1:0] free_out_next;
    logic [vca_pkg::CHAN_OUT_W-1:0] chan_out_next;
    logic [CNT_W+vca_pkg::COUNT_OUT_W-1:0] free_ext;
    logic [CH_W+vca_pkg::CHAN_OUT_W-1:0]   chan_ext;

    logic                           we;
    logic                           start_we;
    logic [CH_W-1:0]                waddr;
    vca_pkg::kind_t                 wkind;
    logic [vca_pkg::ID_W-1:0]       wowner;

    vca_pkg::kind_t                 rd_kind;
    logic [vca_pkg::ID_W-1:0]       rd_owner;
    logic [vca_pkg::TIME_W-1:0]     rd_start;
    vca_pkg::scan_flags_t           flags;
    logic [CH_W-1:0]                unused_idx;
    logic [CH_W-1:0]                wave_idx;

    vca_table #(
        .CHANNELS (CHANNELS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (cnt_reg[CH_W-1:0]),
        .rd_kind  (rd_kind),
        .rd_owner (rd_owner),
        .rd_start (rd_start),
        .we       (we),
        .waddr    (waddr),
        .wkind    (wkind),
        .wowner   (wowner),
        .start_we (start_we),
        .wstart   (now_reg)
    );

    vca_scan_unit #(
        .CHANNELS (CHANNELS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (in_xfer),
        .en         (scan_en),
        .idx        (rd_idx_reg),
        .kind       (rd_kind),
        .owner      (rd_owner),
        .start      (rd_start),
        .id         (id_reg),
        .flags      (flags),
        .unused_idx (unused_idx),
        .wave_idx   (wave_idx)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign channel    = channel_reg;
    assign no_channel = no_channel_reg;
    assign free_count = free_count_reg;

    assign is_release = (func_reg == vca_pkg::FUNC_RELEASE_MUSIC);
    assign is_assign  = (func_reg == vca_pkg::FUNC_ASSIGN_MUSIC) ||
                        (func_reg == vca_pkg::FUNC_ASSIGN_WAVE);

    // scan timing: read issued at cnt, compared in the next cycle
    assign rd_en    = (state_reg == S_SCAN) && (cnt_reg != LAST_CNT);
    assign scan_en  = (state_reg == S_SCAN) && (cnt_reg != '0);

    assign grant_ok = flags.have_unused || flags.have_wave;
    assign chosen   = flags.have_unused ? unused_idx : wave_idx;

    // table writes and the free-channel count
    always_comb
    begin
        we        = 1'b0;
        start_we  = 1'b0;
        waddr     = rd_idx_reg;
        wkind     = vca_pkg::KIND_UNUSED;
        wowner    = vca_pkg::NO_MUSIC;
        free_next = free_reg;
        case (state_reg)
            S_SCAN:
            begin
                // release frees each matching music channel as it passes
                if (scan_en && is_release && flags.match)
                begin
                    we        = 1'b1;
                    free_next = free_reg + 1'b1;
                end
            end
            S_GRANT:
            begin
                waddr = chosen;
                if (grant_ok)
                begin
                    we = 1'b1;
                    if (func_reg == vca_pkg::FUNC_ASSIGN_MUSIC)
                    begin
                        wkind     = vca_pkg::KIND_MUSIC;
                        wowner    = id_reg;
                        free_next = free_reg - 1'b1;
                    end
                    else
                    begin
                        wkind    = vca_pkg::KIND_WAVE;
                        start_we = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output field widths: zero-extend, then keep the low bits
    assign free_ext      = {{vca_pkg::COUNT_OUT_W{1'b0}}, free_next};
    assign free_out_next = free_ext[vca_pkg::COUNT_OUT_W-1:0];
    assign chan_ext      = {{vca_pkg::CHAN_OUT_W{1'b0}}, chosen};
    assign chan_out_next = chan_ext[vca_pkg::CHAN_OUT_W-1:0];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            free_reg       <= LAST_CNT;
            rd_idx_reg     <= '0;
            func_reg       <= '0;
            id_reg         <= '0;
            now_reg        <= '0;
            out_valid_reg  <= 1'b0;
            channel_reg    <= '0;
            no_channel_reg <= 1'b0;
            free_count_reg <= '0;
        end
        else
        begin
            free_reg <= free_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        func_reg <= func;
                        id_reg   <= music_id;
                        now_reg  <= now;
                        cnt_reg  <= '0;
                        if ((func == vca_pkg::FUNC_ASSIGN_MUSIC) ||
                            (func == vca_pkg::FUNC_ASSIGN_WAVE) ||
                            (func == vca_pkg::FUNC_RELEASE_MUSIC))
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            // undefined code: report the count only
                            channel_reg    <= '0;
                            no_channel_reg <= 1'b0;
                            free_count_reg <= free_out_next;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_RESULT;
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_idx_reg <= cnt_reg[CH_W-1:0];
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_CNT)
                    begin
                        if (is_assign)
                        begin
                            state_reg <= S_GRANT;
                        end
                        else
                        begin
                            channel_reg    <= '0;
                            no_channel_reg <= 1'b0;
                            free_count_reg <= free_out_next;
                            out_valid_reg  <= 1'b1;
                            state_reg      <= S_RESULT;
                        end
                    end
                end
                S_GRANT:
                begin
                    channel_reg    <= grant_ok ? chan_out_next : '0;
                    no_channel_reg <= !grant_ok;
                    free_count_reg <= free_out_next;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a request is never taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while a result is pending");

    // the free count never exceeds the table size
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= LAST_CNT)
        else $error("free channel count out of range");

    // a refused assign grants no channel
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_channel) |-> (channel == '0))
        else $error("refused request reports a channel");

    // an accepted request blocks the input on the next cycle
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after a transfer");

endmodule
